// ===== hw/rtl/atd_pkg.sv =====
// Shared types, constants and tables for the affine transform decomposer.
package atd_pkg;

    // Sequencer states of the decomposition core.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SQUARE,
        ST_SQRT,
        ST_DIVIDE,
        ST_ANG_MUL,
        ST_COR_INIT,
        ST_COR_RUN,
        ST_COR_END,
        ST_DONE
    } t_state;

    // Angle being computed by the CORDIC pass.
    typedef enum logic [1:0] {
        ANG_Y,
        ANG_X,
        ANG_Z
    } t_angle;

    // Result fields handed from the core to the output register.
    typedef struct packed {
        logic               valid_res;
        logic               gimbal_locked;
        logic [30:0]        scale_x;
        logic [30:0]        scale_y;
        logic [30:0]        scale_z;
        logic signed [18:0] angle_x;
        logic signed [17:0] angle_y;
        logic signed [18:0] angle_z;
    } t_result;

    // Column index that carries the translation and triggers a result.
    localparam logic [1:0] COL_TRANSLATE = 2'd3;

    // CORDIC datapath width and angle constants in Q30 radians.
    localparam int CW = 34;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic [30:0]          SCALE_MAX   = 31'h7FFF_FFFF;

    // Arctangent of 2^-i in Q30 radians.
    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd843314857;
            5'd1:  v = 32'd497837829;
            5'd2:  v = 32'd263043837;
            5'd3:  v = 32'd133525159;
            5'd4:  v = 32'd67021687;
            5'd5:  v = 32'd33543516;
            5'd6:  v = 32'd16775851;
            5'd7:  v = 32'd8388437;
            5'd8:  v = 32'd4194283;
            5'd9:  v = 32'd2097149;
            5'd31: v = 32'd0;
            default: v = 32'd1 << (5'd30 - idx);
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/atd_core.sv =====
// Iterative decomposition core: square sums, square roots, divisions and CORDIC.
module atd_core #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_zero,
    input  logic [95:0]      i_rd_data,
    input  logic             i_out_free,
    output logic             o_rd_en,
    output logic [1:0]       o_rd_addr,
    output logic             o_busy,
    output logic             o_done,
    output atd_pkg::t_result o_res
);

    localparam int NW  = FRAC_BITS + 2;
    localparam int QW  = FRAC_BITS + 1;
    localparam int CW  = atd_pkg::CW;
    localparam int QSH = 30 - FRAC_BITS;
    localparam logic signed [NW-1:0] ONE     = NW'(1) <<< FRAC_BITS;
    localparam logic [63:0]          ONE_SQ  = 64'd1 << (2 * FRAC_BITS);
    localparam logic signed [CW-1:0] RND_ADD = CW'(1) <<< (QSH - 1);

    // Q30 angle to the output fraction, rounding half up.
    function automatic logic signed [18:0] rnd(input logic signed [CW-1:0] z);
        logic signed [CW-1:0] t;
        t = (z + RND_ADD) >>> QSH;
        return t[18:0];
    endfunction

    atd_pkg::t_state r_state, n_state;
    atd_pkg::t_angle r_ang, n_ang;
    logic [1:0]  r_col, n_col;
    logic [1:0]  r_row, n_row;
    logic [4:0]  r_cnt, n_cnt;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_prod, n_prod;
    logic [33:0] r_rem, n_rem;
    logic [31:0] r_root, n_root;
    logic [QW-1:0] r_quo, n_quo;
    logic signed [NW-1:0] r_n [9];
    logic signed [NW-1:0] n_n [9];
    logic [30:0] r_scl [3];
    logic [30:0] n_scl [3];
    logic        r_lock, n_lock;
    logic        r_zero, n_zero;
    logic signed [CW-1:0] r_x, n_x, r_y, n_y, r_z, n_z;
    logic signed [18:0] r_rx, n_rx, r_rz, n_rz;
    logic signed [17:0] r_ry, n_ry;

    // Selected basis element and its magnitude.
    logic signed [31:0] v_sel;
    logic [31:0]        v_abs;
    always_comb begin
        case (r_row)
            2'd1:    v_sel = i_rd_data[63:32];
            2'd2:    v_sel = i_rd_data[95:64];
            default: v_sel = i_rd_data[31:0];
        endcase
    end
    assign v_abs = v_sel[31] ? 32'(-v_sel) : 32'(v_sel);

    // Shared squarer.
    logic [NW-1:0] s_abs;
    logic [31:0]   m_a;
    logic [63:0]   m_prod;
    assign s_abs  = r_n[2][NW-1] ? NW'(-r_n[2]) : NW'(r_n[2]);
    assign m_a    = (r_state == atd_pkg::ST_ANG_MUL) ? 32'(s_abs) : v_abs;
    assign m_prod = {32'd0, m_a} * {32'd0, m_a};

    // One digit of the square root.
    logic [35:0] sq_t, sq_trial;
    logic        sq_ge;
    assign sq_t     = {r_rem, r_acc[63:62]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign sq_ge    = sq_t >= sq_trial;

    // One bit of the normalizing division.
    logic [33:0] len34, dv_t, dv_a;
    logic        dv_ge, dv_ge0;
    assign len34  = {2'b00, r_root};
    assign dv_t   = {r_rem[32:0], 1'b0};
    assign dv_a   = {2'b00, v_abs};
    assign dv_ge  = dv_t >= len34;
    assign dv_ge0 = dv_a >= len34;

    // Normalized component from the finished quotient.
    logic [QW-1:0]        q_fin;
    logic signed [NW-1:0] q_val;
    logic [3:0]           widx;
    assign q_fin = {r_quo[QW-2:0], dv_ge};
    assign q_val = (r_root == 32'd0) ? '0 :
                   (v_sel[31] ? -$signed(NW'(q_fin)) : $signed(NW'(q_fin)));
    assign widx  = 4'(r_col) * 4'd3 + 4'(r_row);

    // CORDIC operand selection and quadrant fold.
    logic signed [NW-1:0] cy, cx, py, px;
    logic signed [CW-1:0] pz;
    always_comb begin
        case (r_ang)
            atd_pkg::ANG_Y: begin
                cy = -r_n[2];
                cx = $signed(r_root[NW-1:0]);
            end
            atd_pkg::ANG_X: begin
                cy = r_lock ? -r_n[6] : r_n[5];
                cx = r_lock ? r_n[4] : r_n[8];
            end
            default: begin
                cy = r_n[1];
                cx = r_n[0];
            end
        endcase
        px = cx;
        py = cy;
        pz = '0;
        if (cx[NW-1]) begin
            if (!cy[NW-1]) begin
                px = cy;
                py = -cx;
                pz = atd_pkg::HALF_PI_Q30;
            end else begin
                px = -cy;
                py = cx;
                pz = -atd_pkg::HALF_PI_Q30;
            end
        end
    end

    // CORDIC micro-rotation terms and final clamp.
    logic signed [CW-1:0] dx, dy, at, zc;
    assign dx = r_y >>> r_cnt;
    assign dy = r_x >>> r_cnt;
    assign at = $signed({2'b00, atd_pkg::atan_q30(r_cnt)});
    always_comb begin
        zc = r_z;
        if (zc > atd_pkg::PI_Q30) zc = atd_pkg::PI_Q30;
        if (zc < -atd_pkg::PI_Q30) zc = -atd_pkg::PI_Q30;
        if (r_ang == atd_pkg::ANG_Y) begin
            if (zc > atd_pkg::HALF_PI_Q30) zc = atd_pkg::HALF_PI_Q30;
            if (zc < -atd_pkg::HALF_PI_Q30) zc = -atd_pkg::HALF_PI_Q30;
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= atd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_ang  <= n_ang;
        r_col  <= n_col;
        r_row  <= n_row;
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_quo  <= n_quo;
        r_n    <= n_n;
        r_scl  <= n_scl;
        r_lock <= n_lock;
        r_zero <= n_zero;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_rx   <= n_rx;
        r_ry   <= n_ry;
        r_rz   <= n_rz;
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_ang   = r_ang;
        n_col   = r_col;
        n_row   = r_row;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_prod  = r_prod;
        n_rem   = r_rem;
        n_root  = r_root;
        n_quo   = r_quo;
        n_n     = r_n;
        n_scl   = r_scl;
        n_lock  = r_lock;
        n_zero  = r_zero;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_rx    = r_rx;
        n_ry    = r_ry;
        n_rz    = r_rz;
        unique case (r_state)
            atd_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_zero  = i_zero;
                    n_col   = 2'd0;
                    n_state = i_zero ? atd_pkg::ST_DONE : atd_pkg::ST_READ;
                end
            end
            atd_pkg::ST_READ: begin
                n_acc   = '0;
                n_row   = 2'd0;
                n_state = atd_pkg::ST_SQUARE;
            end
            atd_pkg::ST_SQUARE: begin
                // Multiply one row while adding the previous product.
                n_prod = m_prod;
                if (r_row != 2'd0) n_acc = r_acc + r_prod;
                n_row = r_row + 2'd1;
                if (r_row == 2'd3) begin
                    n_rem   = '0;
                    n_root  = '0;
                    n_cnt   = '0;
                    n_state = atd_pkg::ST_SQRT;
                end
            end
            atd_pkg::ST_SQRT: begin
                n_rem  = sq_ge ? 34'(sq_t - sq_trial) : sq_t[33:0];
                n_root = {r_root[30:0], sq_ge};
                n_acc  = r_acc << 2;
                n_cnt  = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_cnt = '0;
                    n_row = 2'd0;
                    if (r_col == atd_pkg::COL_TRANSLATE) begin
                        n_ang   = atd_pkg::ANG_Y;
                        n_state = atd_pkg::ST_COR_INIT;
                    end else begin
                        n_state = atd_pkg::ST_DIVIDE;
                    end
                end
            end
            atd_pkg::ST_DIVIDE: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd0) begin
                    n_rem = dv_ge0 ? 34'(dv_a - len34) : dv_a;
                    n_quo = QW'(dv_ge0);
                    if (r_row == 2'd0) begin
                        n_scl[r_col] = r_root[31] ? atd_pkg::SCALE_MAX : r_root[30:0];
                    end
                end else begin
                    n_rem = dv_ge ? 34'(dv_t - len34) : dv_t;
                    n_quo = q_fin;
                end
                if (r_cnt == 5'(FRAC_BITS)) begin
                    n_n[widx] = q_val;
                    n_cnt     = '0;
                    if (r_row != 2'd2) begin
                        n_row = r_row + 2'd1;
                    end else if (r_col != 2'd2) begin
                        n_col   = r_col + 2'd1;
                        n_state = atd_pkg::ST_READ;
                    end else begin
                        // Basis done: pick the regular or the gimbal-locked path.
                        n_col  = atd_pkg::COL_TRANSLATE;
                        n_row  = 2'd0;
                        n_lock = (r_n[2] == ONE) || (r_n[2] == -ONE);
                        if (n_lock) begin
                            n_ry    = 18'(rnd(r_n[2][NW-1] ? atd_pkg::HALF_PI_Q30
                                                           : -atd_pkg::HALF_PI_Q30));
                            n_rz    = '0;
                            n_ang   = atd_pkg::ANG_X;
                            n_state = atd_pkg::ST_COR_INIT;
                        end else begin
                            n_state = atd_pkg::ST_ANG_MUL;
                        end
                    end
                end
            end
            atd_pkg::ST_ANG_MUL: begin
                // Cosine of the y angle from one minus the sine squared.
                n_prod = m_prod;
                n_row  = r_row + 2'd1;
                if (r_row == 2'd1) begin
                    n_acc   = ONE_SQ - r_prod;
                    n_rem   = '0;
                    n_root  = '0;
                    n_cnt   = '0;
                    n_state = atd_pkg::ST_SQRT;
                end
            end
            atd_pkg::ST_COR_INIT: begin
                n_cnt = '0;
                if (cx == '0 && cy == '0) begin
                    n_z     = '0;
                    n_state = atd_pkg::ST_COR_END;
                end else begin
                    n_x     = CW'(px) <<< QSH;
                    n_y     = CW'(py) <<< QSH;
                    n_z     = pz;
                    n_state = atd_pkg::ST_COR_RUN;
                end
            end
            atd_pkg::ST_COR_RUN: begin
                if (r_y > 0) begin
                    n_x = r_x + dx;
                    n_y = r_y - dy;
                    n_z = r_z + at;
                end else begin
                    n_x = r_x - dx;
                    n_y = r_y + dy;
                    n_z = r_z - at;
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(CORDIC_STEPS - 1)) begin
                    n_state = atd_pkg::ST_COR_END;
                end
            end
            atd_pkg::ST_COR_END: begin
                case (r_ang)
                    atd_pkg::ANG_Y: n_ry = 18'(rnd(zc));
                    atd_pkg::ANG_X: n_rx = rnd(zc);
                    default:        n_rz = rnd(zc);
                endcase
                if (r_lock || r_ang == atd_pkg::ANG_Z) begin
                    n_state = atd_pkg::ST_DONE;
                end else begin
                    n_ang   = (r_ang == atd_pkg::ANG_Y) ? atd_pkg::ANG_X : atd_pkg::ANG_Z;
                    n_state = atd_pkg::ST_COR_INIT;
                end
            end
            atd_pkg::ST_DONE: begin
                if (i_out_free) n_state = atd_pkg::ST_IDLE;
            end
            default: n_state = atd_pkg::ST_IDLE;
        endcase
    end

    // Basis memory read port and status.
    assign o_rd_en   = (r_state == atd_pkg::ST_READ);
    assign o_rd_addr = r_col;
    assign o_busy    = (r_state != atd_pkg::ST_IDLE);
    assign o_done    = (r_state == atd_pkg::ST_DONE);

    // Result, all zero when element (3,3) was zero.
    always_comb begin
        o_res.valid_res     = !r_zero;
        o_res.gimbal_locked = !r_zero && r_lock;
        o_res.scale_x       = r_zero ? '0 : r_scl[0];
        o_res.scale_y       = r_zero ? '0 : r_scl[1];
        o_res.scale_z       = r_zero ? '0 : r_scl[2];
        o_res.angle_x       = r_zero ? '0 : r_rx;
        o_res.angle_y       = r_zero ? '0 : r_ry;
        o_res.angle_z       = r_zero ? '0 : r_rz;
    end

endmodule

// ===== hw/rtl/affine_transform_decompose.sv =====
// Top level of the affine transform decomposer: basis store, handshakes, output register.
//
// A 4x4 column-major Q16.16 transform arrives as four input items, one per column.
// Items for columns 0..2 are written into the basis memory when they are accepted.
// The item for column 3 starts the decomposition and yields one result item with the
// translation, per-axis scale and XYZ Euler angles (or an all-zero result with
// valid_res low when element (3,3) is zero).
// The shared sequencer runs, per basis column, a memory read, three squarings, a
// 32-step square root and three (FRAC_BITS+1)-step divisions, then, unless gimbal
// locked, a 32-step root for the cosine; it ends with three CORDIC passes (one pass
// when gimbal locked). o_stall stays high from the column 3 item until its result
// is loaded into the output register.
// The result sits in an output register; the block takes new items while it waits.
// If the receiver holds i_stall, a finished second result waits in the core and
// the input stays stalled until the output register frees.
// Reset (synchronous, active low) returns the sequencer to idle and drops o_valid;
// the basis memory keeps its contents and is undefined until written.
module affine_transform_decompose #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 18
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_column_index,
    input  logic signed [31:0] i_elem_row0,
    input  logic signed [31:0] i_elem_row1,
    input  logic signed [31:0] i_elem_row2,
    input  logic signed [31:0] i_elem_row3,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_valid_res,
    output logic               o_gimbal_locked,
    output logic signed [31:0] o_translation_x,
    output logic signed [31:0] o_translation_y,
    output logic signed [31:0] o_translation_z,
    output logic [30:0]        o_scale_x,
    output logic [30:0]        o_scale_y,
    output logic [30:0]        o_scale_z,
    output logic signed [18:0] o_angle_x,
    output logic signed [17:0] o_angle_y,
    output logic signed [18:0] o_angle_z
);

    logic             accept, is_trans, core_busy, core_done, rd_en, out_free, load;
    logic [1:0]       rd_addr;
    atd_pkg::t_result res;
    logic [95:0]      r_basis [3];
    logic [95:0]      r_rd_data;
    logic signed [31:0] r_tx, r_ty, r_tz;
    logic             r_out_valid;

    assign accept   = i_valid && !o_stall;
    assign is_trans = (i_column_index == atd_pkg::COL_TRANSLATE);
    assign o_stall  = core_busy;
    assign out_free = !r_out_valid || !i_stall;
    assign load     = core_done && out_free;

    // Basis memory: one column per entry.
    always_ff @(posedge i_clk) begin
        if (accept && !is_trans) begin
            r_basis[i_column_index] <= {i_elem_row2, i_elem_row1, i_elem_row0};
        end
        if (rd_en) begin
            r_rd_data <= r_basis[rd_addr];
        end
    end

    // Translation held from the column 3 item.
    always_ff @(posedge i_clk) begin
        if (accept && is_trans) begin
            r_tx <= i_elem_row0;
            r_ty <= i_elem_row1;
            r_tz <= i_elem_row2;
        end
    end

    atd_core #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept && is_trans),
        .i_zero     (i_elem_row3 == 32'sd0),
        .i_rd_data  (r_rd_data),
        .i_out_free (out_free),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_busy     (core_busy),
        .o_done     (core_done),
        .o_res      (res)
    );

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            o_valid_res     <= res.valid_res;
            o_gimbal_locked <= res.gimbal_locked;
            o_translation_x <= res.valid_res ? r_tx : 32'sd0;
            o_translation_y <= res.valid_res ? r_ty : 32'sd0;
            o_translation_z <= res.valid_res ? r_tz : 32'sd0;
            o_scale_x       <= res.scale_x;
            o_scale_y       <= res.scale_y;
            o_scale_z       <= res.scale_z;
            o_angle_x       <= res.angle_x;
            o_angle_y       <= res.angle_y;
            o_angle_z       <= res.angle_z;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the affine transform decomposer: directed table, then random matrices.
module testbench;

    localparam int ITEM_TARGET = 1200;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;
    localparam int LONG_HOLD = 2000;
    localparam int FRAC = 16;
    localparam int STEPS = 18;
    localparam longint ONE_Q = 64'sd1 << FRAC;
    localparam longint HALF_PI_Q = 64'sd1686629713;
    localparam longint PI_Q = 64'sd3373259426;
    localparam longint SCALE_SAT = 64'h7FFF_FFFF;
    localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
    localparam logic signed [31:0] ONE32 = 32'sh0001_0000;

    // Arctangent of 2^-i in Q30 radians.
    localparam longint ARCTAN_Q30 [0:31] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
        8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};

    // One decomposition result as it appears on the output ports.
    typedef struct {
        logic               vres;
        logic               lock;
        logic signed [31:0] tx, ty, tz;
        logic [30:0]        sx, sy, sz;
        logic signed [18:0] ax;
        logic signed [17:0] ay;
        logic signed [18:0] az;
    } t_decomp;

    // One row of the directed table; zero_res marks a result typed in as all zero.
    typedef struct {
        logic [1:0]         col;
        logic signed [31:0] e0, e1, e2, e3;
        bit                 zero_res;
    } t_column_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_column_index = '0;
    logic signed [31:0] i_elem_row0 = '0;
    logic signed [31:0] i_elem_row1 = '0;
    logic signed [31:0] i_elem_row2 = '0;
    logic signed [31:0] i_elem_row3 = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_valid_res;
    logic               o_gimbal_locked;
    logic signed [31:0] o_translation_x, o_translation_y, o_translation_z;
    logic [30:0]        o_scale_x, o_scale_y, o_scale_z;
    logic signed [18:0] o_angle_x;
    logic signed [17:0] o_angle_y;
    logic signed [18:0] o_angle_z;

    logic signed [31:0] basis_copy [0:8];
    t_decomp            decomp_expected [$];
    int                 mismatch_count = 0;
    int                 items_sent = 0;
    int                 quiet_cycles = 0;
    bit                 idle_enable = 1'b1;
    bit                 hold_request = 1'b0;

    affine_transform_decompose u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_column_index (i_column_index),
        .i_elem_row0    (i_elem_row0),
        .i_elem_row1    (i_elem_row1),
        .i_elem_row2    (i_elem_row2),
        .i_elem_row3    (i_elem_row3),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_valid_res    (o_valid_res),
        .o_gimbal_locked(o_gimbal_locked),
        .o_translation_x(o_translation_x),
        .o_translation_y(o_translation_y),
        .o_translation_z(o_translation_z),
        .o_scale_x      (o_scale_x),
        .o_scale_y      (o_scale_y),
        .o_scale_z      (o_scale_z),
        .o_angle_x      (o_angle_x),
        .o_angle_y      (o_angle_y),
        .o_angle_z      (o_angle_z)
    );

    always #5 i_clk = ~i_clk;

    // Bitwise integer square root, floor.
    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Vectoring CORDIC arctangent, Q(FRAC) inputs, Q30 angle out.
    function automatic longint cordic_atan2(input longint y, input longint x);
        longint z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = HALF_PI_Q;
            end else begin
                x = -y; y = t; z = -HALF_PI_Q;
            end
        end
        x = x <<< (30 - FRAC);
        y = y <<< (30 - FRAC);
        for (int i = 0; i < STEPS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx; y = y - dy; z = z + ARCTAN_Q30[i];
            end else begin
                x = x - dx; y = y + dy; z = z - ARCTAN_Q30[i];
            end
        end
        if (z > PI_Q) z = PI_Q;
        if (z < -PI_Q) z = -PI_Q;
        return z;
    endfunction

    function automatic longint angle_round(input longint a);
        return (a + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
    endfunction

    // Component divided by the column length, truncated toward zero.
    function automatic longint unit_component(input longint v, input longint unsigned len);
        longint unsigned m;
        if (len == 0) return 0;
        m = longint'(v < 0 ? -v : v) << FRAC;
        return v < 0 ? -longint'(m / len) : longint'(m / len);
    endfunction

    // Decomposition of the stored basis with the translation column.
    function automatic t_decomp predict_decomp(input logic signed [31:0] t0, t1, t2, w);
        t_decomp d;
        longint n [0:2][0:2];
        longint v [0:2];
        longint unsigned sum, len;
        longint unsigned scl [0:2];
        longint rx, ry, rz, s, cq;
        d = '{default: '0};
        if (w == 0) return d;
        for (int c = 0; c < 3; c++) begin
            sum = 0;
            for (int r = 0; r < 3; r++) begin
                v[r] = longint'(basis_copy[c * 3 + r]);
                sum = sum + longint'(v[r] * v[r]);
            end
            len = root_floor(sum);
            scl[c] = len > SCALE_SAT ? SCALE_SAT : len;
            for (int r = 0; r < 3; r++) n[c][r] = unit_component(v[r], len);
        end
        s = -n[0][2];
        d.lock = (s >= ONE_Q) || (s <= -ONE_Q);
        if (d.lock) begin
            ry = s > 0 ? HALF_PI_Q : -HALF_PI_Q;
            rx = cordic_atan2(-n[2][0], n[1][1]);
            rz = 0;
        end else begin
            cq = longint'(root_floor(ONE_Q * ONE_Q - s * s));
            ry = cordic_atan2(s, cq);
            if (ry > HALF_PI_Q) ry = HALF_PI_Q;
            if (ry < -HALF_PI_Q) ry = -HALF_PI_Q;
            rx = cordic_atan2(n[1][2], n[2][2]);
            rz = cordic_atan2(n[0][1], n[0][0]);
        end
        d.vres = 1'b1;
        d.tx = t0;
        d.ty = t1;
        d.tz = t2;
        d.sx = scl[0][30:0];
        d.sy = scl[1][30:0];
        d.sz = scl[2][30:0];
        d.ax = 19'(angle_round(rx));
        d.ay = 18'(angle_round(ry));
        d.az = 19'(angle_round(rz));
        return d;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
        mismatch_count++;
    endtask

    // Offers one column item, waits for it to be taken, then maybe idles.
    task automatic push_column(input t_column_row row);
        t_decomp zero_d;
        i_valid <= 1'b1;
        i_column_index <= row.col;
        i_elem_row0 <= row.e0;
        i_elem_row1 <= row.e1;
        i_elem_row2 <= row.e2;
        i_elem_row3 <= row.e3;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        if (row.col == atd_pkg::COL_TRANSLATE) begin
            zero_d = '{default: '0};
            if (row.zero_res) decomp_expected.push_back(zero_d);
            else decomp_expected.push_back(predict_decomp(row.e0, row.e1, row.e2, row.e3));
        end else begin
            for (int r = 0; r < 3; r++)
                basis_copy[row.col * 3 + r] = r == 0 ? row.e0 : (r == 1 ? row.e1 : row.e2);
        end
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [31:0] rand_elem(input int mode);
        case (mode)
            0: return $signed($urandom);
            1: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            2: begin
                case ($urandom_range(0, 4))
                    0: return 32'sd0;
                    1: return MAX32;
                    2: return MIN32;
                    3: return ONE32;
                    default: return -ONE32;
                endcase
            end
            default: return 32'($signed($urandom_range(0, 6)) - 3);
        endcase
    endfunction

    // Random matrix: columns in order, sometimes aligned for gimbal lock.
    task automatic push_random_matrix();
        t_column_row row;
        int mode;
        mode = $urandom_range(0, 3);
        for (int c = 0; c < 4; c++) begin
            row.col = c[1:0];
            row.e0 = rand_elem(mode);
            row.e1 = rand_elem(mode);
            row.e2 = rand_elem(mode);
            row.e3 = $urandom_range(0, 7) == 0 ? 32'sd0 : rand_elem($urandom_range(0, 3));
            row.zero_res = 1'b0;
            if (c == 0 && $urandom_range(0, 9) == 0) begin
                row.e0 = 32'sd0;
                row.e1 = 32'sd0;
                row.e2 = $urandom_range(0, 1) ? $signed($urandom_range(1, 1 << 20))
                                              : -$signed($urandom_range(1, 1 << 20));
            end
            push_column(row);
        end
    endtask

    // Result checking and receiver stall bursts.
    initial begin
        int burst_left;
        int hold_left;
        t_decomp want;
        burst_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                if (decomp_expected.size() == 0) begin
                    report_mismatch("unexpected item", 1, 0);
                end else begin
                    want = decomp_expected.pop_front();
                    if (o_valid_res !== want.vres) report_mismatch("valid_res", o_valid_res, want.vres);
                    if (o_gimbal_locked !== want.lock)
                        report_mismatch("gimbal_locked", o_gimbal_locked, want.lock);
                    if (o_translation_x !== want.tx)
                        report_mismatch("translation_x", o_translation_x, want.tx);
                    if (o_translation_y !== want.ty)
                        report_mismatch("translation_y", o_translation_y, want.ty);
                    if (o_translation_z !== want.tz)
                        report_mismatch("translation_z", o_translation_z, want.tz);
                    if (o_scale_x !== want.sx) report_mismatch("scale_x", o_scale_x, want.sx);
                    if (o_scale_y !== want.sy) report_mismatch("scale_y", o_scale_y, want.sy);
                    if (o_scale_z !== want.sz) report_mismatch("scale_z", o_scale_z, want.sz);
                    if (o_angle_x !== want.ax) report_mismatch("angle_x", o_angle_x, want.ax);
                    if (o_angle_y !== want.ay) report_mismatch("angle_y", o_angle_y, want.ay);
                    if (o_angle_z !== want.az) report_mismatch("angle_z", o_angle_z, want.az);
                end
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                i_stall <= 1'b1;
            end else if (idle_enable && $urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(0, 13);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Stimulus: directed table, random matrices, drain and verdict.
    initial begin
        t_column_row directed [$];
        t_column_row row;
        int matrices;
        // Identity with extreme translation, then the same basis with zero (3,3).
        directed.push_back('{2'd0, ONE32, 0, 0, 0, 0});
        directed.push_back('{2'd1, 0, ONE32, 0, 0, 0});
        directed.push_back('{2'd2, 0, 0, ONE32, 0, 0});
        directed.push_back('{2'd3, MAX32, MIN32, 0, ONE32, 0});
        directed.push_back('{2'd3, MAX32, MAX32, MAX32, 0, 1});
        // Extreme basis values, saturating scale.
        directed.push_back('{2'd0, MIN32, MIN32, MIN32, MAX32, 0});
        directed.push_back('{2'd1, MAX32, MAX32, MAX32, MIN32, 0});
        directed.push_back('{2'd2, MAX32, 0, MIN32, -1, 0});
        directed.push_back('{2'd3, MIN32, MAX32, -1, MIN32, 0});
        // Gimbal lock with positive sine.
        directed.push_back('{2'd0, 0, 0, -ONE32, 0, 0});
        directed.push_back('{2'd1, 0, ONE32, 0, 0, 0});
        directed.push_back('{2'd2, ONE32, 0, 0, 0, 0});
        directed.push_back('{2'd3, 1, -1, 7, -1, 0});
        // Gimbal lock with negative sine, zero-length column, atan2 of zero.
        directed.push_back('{2'd0, 0, 0, 3 * ONE32, 0, 0});
        directed.push_back('{2'd1, 0, 0, 0, 0, 0});
        directed.push_back('{2'd2, 0, -ONE32, 0, 0, 0});
        directed.push_back('{2'd3, 0, 0, 0, MAX32, 0});
        // Negative x components exercise the quadrant fold.
        directed.push_back('{2'd0, -ONE32, -ONE32, 0, 0, 0});
        directed.push_back('{2'd1, 0, -1, 1, 0, 0});
        directed.push_back('{2'd2, 0, 0, -ONE32, 0, 0});
        directed.push_back('{2'd3, -5, 5, 0, 1, 0});

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) push_column(directed[k]);

        matrices = 0;
        while (items_sent < ITEM_TARGET) begin
            idle_enable = (items_sent < ITEM_TARGET - 150) && ((items_sent / 100) % 3 != 2);
            if (matrices == 60) hold_request = 1'b1;
            if (matrices == 150) begin
                i_valid <= 1'b0;
                wait (decomp_expected.size() == 0);
                repeat (DRAIN_CYCLES) @(posedge i_clk);
            end
            if ($urandom_range(0, 9) < 8) begin
                push_random_matrix();
                matrices++;
            end else begin
                // Stray column items, out of order.
                row.col = 2'($urandom_range(0, 3));
                row.e0 = rand_elem($urandom_range(0, 3));
                row.e1 = rand_elem($urandom_range(0, 3));
                row.e2 = rand_elem($urandom_range(0, 3));
                row.e3 = rand_elem($urandom_range(0, 3));
                row.zero_res = 1'b0;
                push_column(row);
            end
        end
        i_valid <= 1'b0;

        wait (decomp_expected.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && decomp_expected.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
